// File: rtl/g3c_pkg.sv
// Shared types and constants for the gray 3x3 convolution stream block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package g3c_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int COL_W        = $clog2(IMAGE_WIDTH);
    localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam int TDATA_W      = 40;
    localparam int PADDR_W      = 4;

    // Gray conversion weights.
    localparam logic [6:0] GRAY_WR = 7'd76;
    localparam logic [7:0] GRAY_WG = 8'd150;
    localparam logic [4:0] GRAY_WB = 5'd30;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_COEF_TOP    = 2'd0;
    localparam logic [1:0] REG_COEF_MID    = 2'd1;
    localparam logic [1:0] REG_COEF_BOTTOM = 2'd2;

    typedef struct packed {
        logic [3:0] keep;
        logic [3:0] strb;
        logic       user;
        logic       last;
        logic       id;
        logic       dest;
    } side_t;

    // One window on its way from the front to the back. Entry 3*r+k holds
    // window row r (0 = oldest line), column k (2 = current pixel).
    typedef struct packed {
        logic [8:0][7:0] win;
        logic            border;
        side_t           side;
    } item_t;

endpackage

// File: rtl/gray_3x3_convolution_stream_top.sv
// Top level of the gray 3x3 convolution stream block: stream ports,
// coefficient registers on the APB-style port, front, queue and back parts.
// Depends on g3c_pkg, g3c_front, g3c_queue and g3c_back.
//
// One RGB pixel per transfer in raster order, one result transfer per pixel,
// at one pixel per clock while the output is not stalled; a result passes the
// stage-1, queue, product and output registers. The line memory has one read
// and one write per clock, which sets that rate. Results in the first two rows
// and columns of a frame are zero; row and column counters wrap at the frame
// size, ignore tlast. The user must write coefficients only while idle (unenforced).
module gray_3x3_convolution_stream_top
    import g3c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // pixel_rgb[23:0], in_keep[27:24], in_strb[31:28], in_id[32], in_dest[33]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // in_user
    input  logic               s_axis_tuser,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pixel_out[23:0], out_keep[27:24], out_strb[31:28], out_id[32], out_dest[33]
    output logic [TDATA_W-1:0] m_axis_tdata,
    // out_user
    output logic               m_axis_tuser,
    output logic               m_axis_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [2:0][23:0] coef_reg;
    logic             cfg_write;
    side_t            in_side;
    side_t            out_side;
    logic [23:0]      pixel_out;
    logic             push;
    logic             full;
    logic             pop;
    logic             not_empty;
    item_t            push_item;
    item_t            pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_COEF_TOP:    coef_reg[0] <= pwdata[23:0];
                REG_COEF_MID:    coef_reg[1] <= pwdata[23:0];
                REG_COEF_BOTTOM: coef_reg[2] <= pwdata[23:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COEF_TOP:    prdata = {8'd0, coef_reg[0]};
            REG_COEF_MID:    prdata = {8'd0, coef_reg[1]};
            REG_COEF_BOTTOM: prdata = {8'd0, coef_reg[2]};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        in_side.keep = s_axis_tdata[27:24];
        in_side.strb = s_axis_tdata[31:28];
        in_side.user = s_axis_tuser;
        in_side.last = s_axis_tlast;
        in_side.id   = s_axis_tdata[32];
        in_side.dest = s_axis_tdata[33];
    end

    g3c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_rgb (s_axis_tdata[23:0]),
        .in_side   (in_side),
        .push      (push),
        .full      (full),
        .push_item (push_item)
    );

    g3c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    g3c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_item    (pop_item),
        .pop       (pop),
        .coefs     (coef_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .pixel_out (pixel_out),
        .out_side  (out_side)
    );

    assign m_axis_tdata = {6'd0, out_side.dest, out_side.id, out_side.strb,
                           out_side.keep, pixel_out};
    assign m_axis_tuser = out_side.user;
    assign m_axis_tlast = out_side.last;

endmodule

// File: rtl/g3c_front.sv
// Front part: accepts pixels, converts them to gray, tracks row and column,
// keeps the two previous lines and the column window. Uses g3c_pkg.
module g3c_front
    import g3c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] pixel_rgb,
    input  side_t       in_side,
    output logic        push,
    input  logic        full,
    output item_t       push_item
);

    logic             accept;
    logic             advance;
    logic [15:0]      gray_sum;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_gray_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_border_reg;
    side_t            s1_side_reg;

    // Each entry holds {older line, newer line} for one column.
    logic [15:0]      line_mem [IMAGE_WIDTH];
    logic [15:0]      rd_data_reg;
    logic [5:0][7:0]  win_reg;

    assign accept  = in_valid && in_ready;
    assign advance = s1_valid_reg && !full;
    assign in_ready = !s1_valid_reg || !full;
    assign push    = advance;

    assign gray_sum = 16'(GRAY_WR * pixel_rgb[7:0])
                    + 16'(GRAY_WG * pixel_rgb[15:8])
                    + 16'(GRAY_WB * pixel_rgb[23:16]);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == COL_W'(IMAGE_WIDTH - 1))
            begin
                col_next = '0;
                if (row_reg == ROW_W'(IMAGE_HEIGHT - 1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_gray_reg   <= gray_sum[15:8];
            s1_col_reg    <= col_reg;
            s1_border_reg <= (row_reg < ROW_W'(2)) || (col_reg < COL_W'(2));
            s1_side_reg   <= in_side;
        end
    end

    // The read for a new pixel and the write-back of the previous one always
    // hit different columns, since a line is at least three pixels wide.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (advance)
        begin
            line_mem[s1_col_reg] <= {rd_data_reg[7:0], s1_gray_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= rd_data_reg[15:8];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rd_data_reg[7:0];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_gray_reg;
        end
    end

    always_comb
    begin
        push_item.win[0] = win_reg[0];
        push_item.win[1] = win_reg[1];
        push_item.win[2] = rd_data_reg[15:8];
        push_item.win[3] = win_reg[2];
        push_item.win[4] = win_reg[3];
        push_item.win[5] = rd_data_reg[7:0];
        push_item.win[6] = win_reg[4];
        push_item.win[7] = win_reg[5];
        push_item.win[8] = s1_gray_reg;
        push_item.border = s1_border_reg;
        push_item.side   = s1_side_reg;
    end

endmodule

// File: rtl/g3c_queue.sv
// Short queue of windows between the front and the back part.
// Uses item_t and the queue depth from g3c_pkg.
module g3c_queue
    import g3c_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    item_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/g3c_back.sv
// Back part: nine coefficient products, 16-bit wrapped sum, clamp, invert,
// border zeroing and the output register. Uses item_t and side_t from g3c_pkg.
module g3c_back
    import g3c_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             pop,
    input  logic [2:0][23:0] coefs,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [23:0]      pixel_out,
    output side_t            out_side
);

    logic                    out_free;
    logic                    p_load;
    logic [8:0][15:0]        prod;
    logic signed [16:0]      prod_full [9];

    logic                    p_valid_reg;
    logic                    p_valid_next;
    logic [8:0][15:0]        prod_reg;
    logic                    p_border_reg;
    side_t                   p_side_reg;

    logic [15:0]             sum;
    logic [7:0]              clamped;
    logic [23:0]             result;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [23:0]             pixel_reg;
    side_t                   side_reg;

    assign out_free = !m_valid_reg || out_ready;
    assign pop      = q_valid && (!p_valid_reg || out_free);
    assign p_load   = p_valid_reg && out_free;

    // Signed coefficient times unsigned pixel; only the low 16 bits matter.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            prod_full[i] = $signed(coefs[i / 3][8 * (i % 3) +: 8])
                         * $signed({1'b0, q_item.win[i]});
            prod[i] = prod_full[i][15:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum = sum + prod_reg[i];
        end
    end

    always_comb
    begin
        if (sum[15])
        begin
            clamped = 8'd0;
        end
        else if (sum[14:8] != '0)
        begin
            clamped = 8'hFF;
        end
        else
        begin
            clamped = sum[7:0];
        end
        result = p_border_reg ? 24'd0 : {3{~clamped}};
    end

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (pop)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_load)
        begin
            p_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg     <= prod;
            p_border_reg <= q_item.border;
            p_side_reg   <= q_item.side;
        end
        if (p_load)
        begin
            pixel_reg <= result;
            side_reg  <= p_side_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign pixel_out = pixel_reg;
    assign out_side  = side_reg;

endmodule
